// ----- design/bdq_pkg.sv -----
package bdq_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int WORD_W    = 32;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd1;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_LIST       = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [WORD_W-1:0] value;
  } bdq_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value_res;
    logic [1:0]               status;
    logic                     last;
  } bdq_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_LIST
  } bdq_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       take_in;
    logic       push_front;
    logic       push_back;
    logic       pop_front;
    logic       pop_back;
    logic       list_start;
    logic       list_next;
    logic       out_ld;
    logic       out_rdata;
    logic [1:0] out_status;
    logic       out_last;
  } bdq_ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       full;
    logic       empty;
    logic       list_last;
    logic       out_free;
  } bdq_sts_t;

endpackage

// ----- design/bdq_ctrl.sv -----
module bdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bdq_pkg::bdq_sts_t sts,
  output bdq_pkg::bdq_ctl_t ctl
);

  bdq_pkg::bdq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    ctl            = '0;
    ctl.out_status = bdq_pkg::STAT_OK;
    ctl.out_last   = 1'b1;
    in_ready       = 1'b0;
    case (state_r)
      bdq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.take_in = 1'b1;
          state_nxt   = bdq_pkg::S_EXEC;
        end
      end
      bdq_pkg::S_EXEC: begin
        case (sts.cmd)
          bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
            if (sts.out_free) begin
              ctl.out_ld = 1'b1;
              if (sts.full) begin
                ctl.out_status = bdq_pkg::STAT_FULL;
              end else if (sts.cmd == bdq_pkg::CMD_PUSH_FRONT) begin
                ctl.push_front = 1'b1;
              end else begin
                ctl.push_back = 1'b1;
              end
              state_nxt = bdq_pkg::S_IDLE;
            end
          end
          bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK, bdq_pkg::CMD_LIST: begin
            if (sts.empty) begin
              if (sts.out_free) begin
                ctl.out_ld     = 1'b1;
                ctl.out_status = bdq_pkg::STAT_EMPTY;
                state_nxt      = bdq_pkg::S_IDLE;
              end
            end else if (sts.cmd == bdq_pkg::CMD_POP_FRONT) begin
              ctl.pop_front = 1'b1;
              state_nxt     = bdq_pkg::S_POP;
            end else if (sts.cmd == bdq_pkg::CMD_POP_BACK) begin
              ctl.pop_back = 1'b1;
              state_nxt    = bdq_pkg::S_POP;
            end else begin
              ctl.list_start = 1'b1;
              state_nxt      = bdq_pkg::S_LIST;
            end
          end
          default: begin
            if (sts.out_free) begin
              ctl.out_ld = 1'b1;
              state_nxt  = bdq_pkg::S_IDLE;
            end
          end
        endcase
      end
      bdq_pkg::S_POP: begin
        if (sts.out_free) begin
          ctl.out_ld    = 1'b1;
          ctl.out_rdata = 1'b1;
          state_nxt     = bdq_pkg::S_IDLE;
        end
      end
      bdq_pkg::S_LIST: begin
        if (sts.out_free) begin
          ctl.out_ld    = 1'b1;
          ctl.out_rdata = 1'b1;
          ctl.out_last  = sts.list_last;
          if (sts.list_last) begin
            state_nxt = bdq_pkg::S_IDLE;
          end else begin
            // fetch the next entry while this one goes out
            ctl.list_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = bdq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/bdq_dp.sv -----
module bdq_dp #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bdq_pkg::bdq_in_t  in_data,
  output bdq_pkg::bdq_out_t out_data,
  output logic              out_valid,
  input  logic              out_ready,
  input  bdq_pkg::bdq_ctl_t ctl,
  output bdq_pkg::bdq_sts_t sts
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [bdq_pkg::WORD_W-1:0] mem [DEPTH];
  logic [bdq_pkg::WORD_W-1:0] rdata_r;

  logic [2:0]                 cmd_r;
  logic [bdq_pkg::WORD_W-1:0] val_r;
  logic [IDX_W-1:0]           head_r, head_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [CNT_W-1:0]           idx_r, idx_nxt;
  logic                       out_valid_r, out_valid_nxt;
  bdq_pkg::bdq_out_t          out_r;

  logic [IDX_W-1:0] head_inc, head_dec, addr;
  logic [CNT_W-1:0] off;
  logic [SUM_W-1:0] sum;
  logic             mem_we, mem_re;

  assign head_inc = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - 1'b1;

  // slot = (head + offset) mod DEPTH, offset below DEPTH
  always_comb begin
    off = '0;
    if (ctl.push_back) begin
      off = cnt_r;
    end else if (ctl.pop_back) begin
      off = cnt_r - 1'b1;
    end else if (ctl.list_next) begin
      off = idx_r + 1'b1;
    end
    sum = SUM_W'(head_r) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    addr = ctl.push_front ? head_dec : sum[IDX_W-1:0];
  end

  assign mem_we = ctl.push_front | ctl.push_back;
  assign mem_re = ctl.pop_front | ctl.pop_back | ctl.list_start | ctl.list_next;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= val_r;
    end
    if (mem_re) begin
      rdata_r <= mem[addr];
    end
  end

  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    if (ctl.push_front) begin
      head_nxt = head_dec;
      cnt_nxt  = cnt_r + 1'b1;
    end
    if (ctl.push_back) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (ctl.pop_front) begin
      head_nxt = head_inc;
      cnt_nxt  = cnt_r - 1'b1;
    end
    if (ctl.pop_back) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    if (ctl.list_start) begin
      idx_nxt = '0;
    end
    if (ctl.list_next) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
      idx_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take_in) begin
      cmd_r <= in_data.cmd;
      val_r <= in_data.value;
    end
  end

  // output register: hold until taken
  assign out_valid_nxt = ctl.out_ld | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_ld) begin
      out_r.value_res <= ctl.out_rdata ? rdata_r : '0;
      out_r.status    <= ctl.out_status;
      out_r.last      <= ctl.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.cmd       = cmd_r;
  assign sts.full      = (cnt_r == CNT_W'(DEPTH));
  assign sts.empty     = (cnt_r == '0);
  assign sts.list_last = ((idx_r + 1'b1) == cnt_r);
  assign sts.out_free  = ~out_valid_r | out_ready;

endmodule

// ----- design/bounded_deque_core.sv -----
// Channel  Ports                          Payload
// -------  -----------------------------  ----------------------------
// in       in_valid / in_ready / in_data   cmd, value (bdq_in_t)
// out      out_valid / out_ready / out_data value_res, status, last
//
// One item at a time. Push and empty/full results load in the execute
// state; a pop first passes a state for the registered read of the entry
// memory. A list reads the entries in order through the single read port,
// each read overlapping the output of the entry before. The result register
// lets the next item be accepted while the last result waits; a stalled
// result channel holds the controller in its loading state. Reset (rst_n
// low, synchronous) empties the deque at once; entry memory is not cleared.
module bounded_deque_core #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bdq_pkg::bdq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bdq_pkg::bdq_out_t out_data
);

  bdq_pkg::bdq_ctl_t ctl;
  bdq_pkg::bdq_sts_t sts;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  bdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule
